// ===== rtl/rbsi_pkg.sv =====
// Package for the ray/box slab test: shared result types and lane status.
// No dependencies.
package rbsi_pkg;

    // Per-axis outcome handed from a lane to the merge stage
    typedef struct packed {
        logic zero_dir;   // direction component was zero
        logic outside;    // zero direction and origin outside the slab
    } t_lane_flags;

endpackage

// ===== rtl/ray_box_slab_intersection.sv =====
// Pipeline: load stage, one stage per quotient bit, then the merge register.
// Throughput: one word per cycle, set by the fully pipelined per-axis dividers;
// stalls freeze the whole pipeline.
// Reset: synchronous, active low; clears the valid bits of every stage.
// Top level: two axis lanes and a merge stage. Depends on rbsi_pkg, rbsi_lane.
module ray_box_slab_intersection
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y, origin_x, origin_y, dir_x, dir_y
    input  logic [8*COORD_WIDTH-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // hit, t_near, t_far, zero pad to bytes
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
    localparam int CW  = COORD_WIDTH;
    localparam int LAT = CW + FRAC_BITS + 2;
    localparam int OW  = ((2*CW+1+7)/8)*8;

    logic               r_vld [LAT];
    logic               w_en;
    logic               r_ov;
    logic [OW-1:0]      r_od;
    logic signed [CW-1:0] w_t1 [2], w_t2 [2];
    t_lane_flags        w_fl [2];

    // advance when the output slot is free or being taken
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    for (genvar a = 0; a < 2; a++) begin : g_lane
        rbsi_lane #(.CW(CW), .FB(FRAC_BITS), .LAT(LAT)) u_lane (
            .i_clk(i_clk), .i_en(w_en),
            .i_lo (s_axis_tdata[(0+a)*CW +: CW]),
            .i_hi (s_axis_tdata[(2+a)*CW +: CW]),
            .i_org(s_axis_tdata[(4+a)*CW +: CW]),
            .i_dir(s_axis_tdata[(6+a)*CW +: CW]),
            .o_t1(w_t1[a]), .o_t2(w_t2[a]), .o_flags(w_fl[a]));
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // merge the two axes
    logic signed [CW-1:0] w_nx, w_fx, w_n, w_f;
    logic                 w_miss;
    always_comb begin
        w_nx = {1'b1, {(CW-1){1'b0}}};
        w_fx = {1'b0, {(CW-1){1'b1}}};
        w_miss = 1'b0;
        if (w_fl[0].outside) w_miss = 1'b1;
        else if (!w_fl[0].zero_dir) begin
            w_nx = w_t1[0];
            w_fx = w_t2[0];
            if (w_fx < 0) w_miss = 1'b1;
        end
        w_n = w_nx;
        w_f = w_fx;
        if (w_fl[1].outside) w_miss = 1'b1;
        else if (!w_fl[1].zero_dir) begin
            if (w_t1[1] > w_n) w_n = w_t1[1];
            if (w_t2[1] < w_f) w_f = w_t2[1];
            if (w_n > w_f || w_f < 0) w_miss = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_vld[LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od <= w_miss ? '0 : OW'({w_f, w_n, 1'b1});
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_od))
        else $error("output word changed under stall");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_od[0] |-> r_od[2*CW:1] == '0)
        else $error("miss carries nonzero interval");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_od[0] |-> $signed(r_od[CW:1]) <= $signed(r_od[2*CW:CW+1]))
        else $error("hit with near above far");
`endif
endmodule

// ===== rtl/rbsi_div.sv =====
// Pipelined restoring divider: ((num << FB) / den), truncated, saturated.
// Depends on nothing; one quotient bit per stage, one item per cycle while i_en is high.
module rbsi_div #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW:0]   i_num,
    input  logic signed [CW-1:0] i_den,
    output logic signed [CW-1:0] o_quo
);
    localparam int NB = CW + 1 + FB;   // dividend bits
    localparam int QB = NB;            // quotient bits kept
    localparam int RB = CW + 1;        // remainder bits

    // pipeline stages
    logic [NB-1:0] r_n   [NB+1];
    logic [RB-1:0] r_rem [NB+1];
    logic [CW-1:0] r_d   [NB+1];
    logic [QB-1:0] r_q   [NB+1];
    logic          r_neg [NB+1];

    logic [CW:0]   w_num_abs;
    logic [CW-1:0] w_den_abs;

    assign w_num_abs = i_num[CW] ? (~i_num + 1'b1) : i_num;
    assign w_den_abs = i_den[CW-1] ? (~i_den + 1'b1) : i_den;

    // load stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= {w_num_abs, {FB{1'b0}}};
            r_rem[0] <= '0;
            r_d[0]   <= w_den_abs;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[CW] ^ i_den[CW-1];
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < NB; s++) begin : g_stage
        logic [RB:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_rem[s], r_n[s][NB-1]};
        assign w_ge = w_sh >= {1'b0, 1'b0, r_d[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]   <= {r_n[s][NB-2:0], 1'b0};
                r_rem[s+1] <= w_ge ? RB'(w_sh - {2'b0, r_d[s]}) : RB'(w_sh);
                r_d[s+1]   <= r_d[s];
                r_q[s+1]   <= {r_q[s][QB-2:0], w_ge};
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // saturate and sign
    localparam logic [QB-1:0] TMAXQ = QB'((64'd1 << (CW - 1)) - 1);
    always_comb begin
        if (r_neg[NB]) begin
            if (r_q[NB] > TMAXQ + 1'b1) o_quo = {1'b1, {(CW-1){1'b0}}};
            else                        o_quo = CW'(~r_q[NB] + 1'b1);
        end else begin
            if (r_q[NB] > TMAXQ) o_quo = {1'b0, {(CW-1){1'b1}}};
            else                 o_quo = CW'(r_q[NB]);
        end
    end
endmodule

// ===== rtl/rbsi_lane.sv =====
// One axis lane: two slab quotients, ordered, plus zero-direction flags.
// Depends on rbsi_pkg and rbsi_div.
module rbsi_lane
    import rbsi_pkg::*;
#(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int LAT = 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_lo,
    input  logic signed [CW-1:0] i_hi,
    input  logic signed [CW-1:0] i_org,
    input  logic signed [CW-1:0] i_dir,
    output logic signed [CW-1:0] o_t1,
    output logic signed [CW-1:0] o_t2,
    output t_lane_flags          o_flags
);
    logic signed [CW:0]   w_dlo, w_dhi;
    logic signed [CW-1:0] w_q1, w_q2;
    t_lane_flags          r_fl [LAT];
    t_lane_flags          n_fl;
    logic signed [CW-1:0] w_dsafe;

    assign w_dlo = {i_lo[CW-1], i_lo} - {i_org[CW-1], i_org};
    assign w_dhi = {i_hi[CW-1], i_hi} - {i_org[CW-1], i_org};
    assign w_dsafe = (i_dir == '0) ? CW'(1) : i_dir;

    rbsi_div #(.CW(CW), .FB(FB)) u_div_lo (
        .i_clk(i_clk), .i_en(i_en), .i_num(w_dlo), .i_den(w_dsafe), .o_quo(w_q1));
    rbsi_div #(.CW(CW), .FB(FB)) u_div_hi (
        .i_clk(i_clk), .i_en(i_en), .i_num(w_dhi), .i_den(w_dsafe), .o_quo(w_q2));

    assign n_fl.zero_dir = (i_dir == '0);
    assign n_fl.outside  = (i_dir == '0) && ((i_org < i_lo) || (i_org > i_hi));

    // carry flags alongside the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fl[0] <= n_fl;
            for (int k = 1; k < LAT; k++) r_fl[k] <= r_fl[k-1];
        end
    end

    // order the quotients
    assign o_t1 = (w_q1 > w_q2) ? w_q2 : w_q1;
    assign o_t2 = (w_q1 > w_q2) ? w_q1 : w_q2;
    assign o_flags = r_fl[LAT-1];
endmodule

// ===== verif/ray_box_slab_intersection_test.sv =====
// Testbench for ray_box_slab_intersection: drives ray/box words on the input
// stream and checks each result word against a built-in slab-test predictor.
// Depends on the RTL top level (and rbsi_pkg through it).
`timescale 1ns / 100ps

module ray_box_slab_intersection_test;

    localparam int CW      = 32;
    localparam int FB      = 16;
    localparam int OUT_W   = ((2*CW+1+7)/8)*8;
    localparam int LATENCY = CW+FB+3;
    localparam logic signed [63:0] T_HI = 64'sd2147483647;
    localparam logic signed [63:0] T_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [CW-1:0] dir_y, dir_x, org_y, org_x;
        logic signed [CW-1:0] max_y, max_x, min_y, min_x;
    } t_ray_box;

    typedef struct {
        logic            hit;
        logic [CW-1:0]   t_near;
        logic [CW-1:0]   t_far;
    } t_span;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    // box_min_x, box_min_y, box_max_x, box_max_y, origin_x, origin_y, dir_x, dir_y
    logic [8*CW-1:0]    s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    // hit, t_near, t_far, zero pad
    logic [OUT_W-1:0]   m_axis_tdata;

    t_span  expected_spans[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     rays_sent = 0;
    int     hits_seen = 0;
    bit     sink_idle_en = 1;
    bit     src_idle_en = 1;
    int     hold_off = 0;
    bit     long_hold_go = 0;
    bit     long_hold_done = 0;
    int     long_hold_left = 0;

    ray_box_slab_intersection u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Exact fixed-point quotient, truncated toward zero, saturated
    function automatic logic signed [63:0] slab_div(logic signed [63:0] num,
                                                     logic signed [63:0] den);
        logic signed [127:0] q;
        q = ($signed({{64{num[63]}}, num}) <<< FB) / $signed({{64{den[63]}}, den});
        if (q > T_HI) return T_HI;
        if (q < T_LO) return T_LO;
        return q[63:0];
    endfunction

    // Predict entry/exit span of the ray through the box
    function automatic t_span predict_span(t_ray_box r);
        logic signed [63:0] near, far, lo, hi, org, dir, t1, t2, tmp;
        t_span s;
        near = T_LO;
        far  = T_HI;
        s = '{0, 0, 0};
        for (int ax = 0; ax < 2; ax++) begin
            lo  = ax ? r.min_y : r.min_x;
            hi  = ax ? r.max_y : r.max_x;
            org = ax ? r.org_y : r.org_x;
            dir = ax ? r.dir_y : r.dir_x;
            if (dir == 0) begin
                if (org < lo || org > hi) return s;
                continue;
            end
            t1 = slab_div(lo - org, dir);
            t2 = slab_div(hi - org, dir);
            if (t1 > t2) begin
                tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t1 > near) near = t1;
            if (t2 < far) far = t2;
            if (near > far || far < 0) return s;
        end
        s.hit = 1;
        s.t_near = near[CW-1:0];
        s.t_far = far[CW-1:0];
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    // Send one ray/box word, with optional random idle before it
    task automatic send_ray(t_ray_box r);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= r;
        expected_spans.push_back(predict_span(r));
        do @(posedge i_clk); while (!s_axis_tready);
        rays_sent++;
    endtask

    // Check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_span want;
            results_seen++;
            if (expected_spans.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[CW-1:0], '0);
            end else begin
                want = expected_spans.pop_front();
                if (m_axis_tdata[0] != want.hit)
                    report_mismatch("hit", CW'(m_axis_tdata[0]), CW'(want.hit));
                if (m_axis_tdata[CW:1] != want.t_near)
                    report_mismatch("t_near", m_axis_tdata[CW:1], want.t_near);
                if (m_axis_tdata[2*CW:CW+1] != want.t_far)
                    report_mismatch("t_far", m_axis_tdata[2*CW:CW+1], want.t_far);
                hits_seen += m_axis_tdata[0];
            end
        end
    end

    // Long receiver hold-off, counted in cycles once requested
    always @(posedge i_clk) begin
        if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_left <= 4 * LATENCY;
            long_hold_done <= 1;
        end
    end

    // Receiver: random stall bursts, or hold during the long hold-off
    always @(posedge i_clk) begin
        if (long_hold_left > 0) begin
            m_axis_tready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            hold_off <= $urandom_range(1, 15);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(bit narrow);
        if (narrow) return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
        case ($urandom_range(0, 5))
            0: return T_HI[CW-1:0];
            1: return T_LO[CW-1:0];
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_ray_box make_ray(bit narrow);
        t_ray_box r;
        logic signed [CW-1:0] a, b;
        a = rand_coord(narrow); b = rand_coord(narrow);
        r.min_x = (a < b || $urandom_range(0, 9) == 0) ? a : b;
        r.max_x = (r.min_x == a) ? b : a;
        a = rand_coord(narrow); b = rand_coord(narrow);
        r.min_y = (a < b || $urandom_range(0, 9) == 0) ? a : b;
        r.max_y = (r.min_y == a) ? b : a;
        r.org_x = rand_coord(narrow);
        r.org_y = rand_coord(narrow);
        r.dir_x = ($urandom_range(0, 7) == 0) ? 0 : rand_coord(narrow);
        r.dir_y = ($urandom_range(0, 7) == 0) ? 0 : rand_coord(narrow);
        return r;
    endfunction

    // Extremes, zero directions, swapped bounds, saturation
    task automatic test_directed();
        localparam logic signed [CW-1:0] ONE   = 32'sh00010000;
        localparam logic signed [CW-1:0] C_MAX = T_HI[CW-1:0];
        localparam logic signed [CW-1:0] C_MIN = T_LO[CW-1:0];
        t_ray_box r;
        r = '{dir_y: 0, dir_x: ONE, org_y: ONE, org_x: -ONE, max_y: 2*ONE,
              max_x: 2*ONE, min_y: 0, min_x: 0};
        send_ray(r);                        // plain hit
        r.dir_x = -ONE; send_ray(r);        // pointing away
        r.dir_x = 0; send_ray(r);           // zero dir, origin outside
        r.org_x = ONE; send_ray(r);         // both dirs zero, origin inside
        r.min_x = 2*ONE; r.max_x = 0; send_ray(r);  // swapped bounds
        r = '{dir_y: 1, dir_x: 1, org_y: C_MIN, org_x: C_MIN, max_y: C_MAX,
              max_x: C_MAX, min_y: C_MIN, min_x: C_MIN};
        send_ray(r);                        // positive saturation
        r.dir_x = -1; r.dir_y = C_MIN; send_ray(r);
        r = '{dir_y: C_MAX, dir_x: C_MIN, org_y: C_MAX, org_x: C_MAX, max_y: C_MIN,
              max_x: C_MIN, min_y: C_MAX, min_x: C_MAX};
        send_ray(r);
        r = '{default: '1}; send_ray(r);
        r = '{default: '0}; send_ray(r);
        r = '{default: C_MIN}; send_ray(r);
        r = '{default: C_MAX}; send_ray(r);
        r.dir_x = ONE; r.org_x = 0; r.min_x = ONE; r.max_x = ONE; send_ray(r);
    endtask

    task automatic test_random(int count, bit narrow);
        repeat (count) send_ray(make_ray(narrow));
    endtask

    // Stall the receiver long enough to fill the pipeline and back up the input
    task automatic test_backpressure();
        long_hold_go = 1;
        repeat (3 * LATENCY) send_ray(make_ray($urandom_range(0, 1)));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 0;
        while (expected_spans.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random(800, 1);
        test_backpressure();
        test_random(600, 0);
        sink_idle_en = 0;
        src_idle_en = 0;
        test_random(150, 1);
        drain();
        $display("sent %0d rays, checked %0d results, %0d hits, %0d mismatches",
                 rays_sent, results_seen, hits_seen, mismatches);
        if (mismatches == 0 && expected_spans.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (expected_spans.size() != 0)
                $display("%0d results never arrived", expected_spans.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
